// File: rtl/core/crlzw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crlzw_pkg
// shared types and constants for the 12-bit hashed lzw decoder core
// ----------------------------------------------------------------------------
package crlzw_pkg;

  localparam int TABLE_SIZE = 4096;
  localparam int CODE_W     = 12;
  localparam int SP_W       = 13;

  localparam logic [11:0] ENTRIES_INIT   = 12'd3840;
  localparam logic [15:0] ROOT_HASH_PRED = 16'hFFFF;
  localparam logic [12:0] NO_PREFIX      = 13'h1000;
  localparam logic [15:0] SQ_OR_BIT      = 16'h0800;
  localparam logic [15:0] MUL_CONST      = 16'd15073;
  localparam logic [11:0] PROBE_STEP     = 12'd101;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_PULL  = 2'd2;

  localparam logic [2:0] STS_NONE     = 3'd0;
  localparam logic [2:0] STS_DECODED  = 3'd1;
  localparam logic [2:0] STS_BYTE     = 3'd2;
  localparam logic [2:0] STS_OVERFLOW = 3'd3;
  localparam logic [2:0] STS_EMPTY    = 3'd4;

  typedef struct packed {
    logic        used;
    logic [12:0] prefix;
    logic [11:0] chain;
    logic [7:0]  follower;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SEED,
    ST_HASH,
    ST_HRD,
    ST_LOOK0,
    ST_CHAIN,
    ST_PROBE,
    ST_LINK,
    ST_WRITE,
    ST_DWALK,
    ST_PULL,
    ST_OUT
  } state_t;

endpackage

// File: rtl/core/crlzw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crlzw_ram
// single-port synchronous ram with registered read
// ----------------------------------------------------------------------------
module crlzw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/core/arc_crunch_lzw_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_crunch_lzw_decoder_core
// 12-bit lzw decoder with hashed string table placement
//
// channel  dir  payload
// s_*      in   tuser: opcode[1:0]; tdata: data_byte[7:0]
// m_*      out  tuser: status[2:0]; tdata: out_byte[7:0], string_length[20:8]
// apb      in   reg 0 at 0x0: hash_mode
//
// start: clear of all 4096 table entries, then each root is seeded, hashed,
// looked up and written on a free slot; code: the string is walked through the
// table ram a byte at a time, then the new entry is hashed, looked up and
// written after any chain or probe reads and a link write; pull: one stack read
// reset runs the same clear and seeding pass, no item is taken meanwhile
// a finished item waits in the output register while the next is accepted
// ----------------------------------------------------------------------------
module arc_crunch_lzw_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic [1:0]  s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // out_byte, string_length, zero pad
  output logic [2:0]  m_tuser,   // status
  output logic        m_tlast,   // last_byte
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  crlzw_pkg::state_t state, state_next;
  crlzw_pkg::entry_t rd, tbl_wdata, tail_q;

  logic        tbl_we;
  logic [11:0] tbl_addr;
  logic        stk_we;
  logic [11:0] stk_addr;
  logic [7:0]  stk_wdata, stk_rdata;

  logic        hash_mode, seed_mode, from_reset, seeding, first;
  logic [12:0] clr_cnt, sp, sp_dec, sp_inc;
  logic [7:0]  seed_i;
  logic [15:0] pred_q;
  logic [7:0]  foll_q;
  logic [12:0] stored_q;
  logic [31:0] prod_q, prod;
  logic [15:0] hsum, mul_a, mul_b;
  logic        mode;
  logic [11:0] hash_val, slot, probe, wr_slot, pcnt;
  logic [11:0] prev, code_q, entries_left, partial, code_in;
  logic [7:0]  final_char;
  logic [1:0]  phase;
  logic        first_seen;
  logic [2:0]  res_status;
  logic [7:0]  res_byte;
  logic [12:0] res_len;
  logic        res_last;
  logic        acc, out_free, add_fail, cfg_wr;

  assign pready   = 1'b1;
  assign prdata   = {31'd0, hash_mode};
  assign cfg_wr   = psel && penable && pwrite && !paddr[2];
  assign s_tready = (state == crlzw_pkg::ST_IDLE);
  assign acc      = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign sp_dec   = sp - 13'd1;
  assign sp_inc   = sp + 13'd1;
  assign add_fail = rd.used && (pcnt == 12'hFFF);

  assign code_in = (phase == 2'd1) ? (partial | {8'd0, s_tdata[7:4]})
                                   : (partial | {4'd0, s_tdata});

  assign mode     = seeding ? seed_mode : hash_mode;
  assign hsum     = pred_q + {8'd0, foll_q};
  assign mul_a    = mode ? hsum : (hsum | crlzw_pkg::SQ_OR_BIT);
  assign mul_b    = mode ? crlzw_pkg::MUL_CONST : (hsum | crlzw_pkg::SQ_OR_BIT);
  assign prod     = mul_a * mul_b;
  assign hash_val = mode ? prod_q[11:0] : prod_q[17:6];

  crlzw_ram #(.WIDTH($bits(crlzw_pkg::entry_t)), .DEPTH(crlzw_pkg::TABLE_SIZE)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .addr  (tbl_addr),
    .wdata (tbl_wdata),
    .rdata (rd)
  );

  crlzw_ram #(.WIDTH(8), .DEPTH(crlzw_pkg::TABLE_SIZE)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .addr  (stk_addr),
    .wdata (stk_wdata),
    .rdata (stk_rdata)
  );

  always_comb begin
    state_next = state;
    tbl_we     = 1'b0;
    tbl_addr   = slot;
    tbl_wdata  = '0;
    stk_we     = 1'b0;
    stk_addr   = sp_dec[11:0];
    stk_wdata  = rd.follower;
    unique case (state)
      crlzw_pkg::ST_IDLE: begin
        if (acc) begin
          priority case (s_tuser)
            crlzw_pkg::OP_START: state_next = crlzw_pkg::ST_CLEAR;
            crlzw_pkg::OP_BYTE: begin
              if (phase == 2'd0) begin
                state_next = crlzw_pkg::ST_OUT;
              end else begin
                tbl_addr   = code_in;
                state_next = crlzw_pkg::ST_DWALK;
              end
            end
            crlzw_pkg::OP_PULL: begin
              state_next = (sp == 13'd0) ? crlzw_pkg::ST_OUT : crlzw_pkg::ST_PULL;
            end
            default: state_next = crlzw_pkg::ST_OUT;
          endcase
        end
      end
      crlzw_pkg::ST_CLEAR: begin
        tbl_we   = 1'b1;
        tbl_addr = clr_cnt[11:0];
        if (clr_cnt[11:0] == 12'hFFF) begin
          state_next = crlzw_pkg::ST_SEED;
        end
      end
      crlzw_pkg::ST_SEED: state_next = crlzw_pkg::ST_HASH;
      crlzw_pkg::ST_HASH: state_next = crlzw_pkg::ST_HRD;
      crlzw_pkg::ST_HRD: begin
        tbl_addr   = hash_val;
        state_next = crlzw_pkg::ST_LOOK0;
      end
      crlzw_pkg::ST_LOOK0, crlzw_pkg::ST_CHAIN: begin
        if (state == crlzw_pkg::ST_LOOK0 && !rd.used) begin
          state_next = crlzw_pkg::ST_WRITE;
        end else if (rd.chain != 12'd0) begin
          tbl_addr   = rd.chain;
          state_next = crlzw_pkg::ST_CHAIN;
        end else begin
          tbl_addr   = slot + crlzw_pkg::PROBE_STEP;
          state_next = crlzw_pkg::ST_PROBE;
        end
      end
      crlzw_pkg::ST_PROBE: begin
        if (!rd.used) begin
          state_next = crlzw_pkg::ST_LINK;
        end else if (add_fail) begin
          state_next = seeding ? ((seed_i == 8'hFF) ? (from_reset ? crlzw_pkg::ST_IDLE
                                                                  : crlzw_pkg::ST_OUT)
                                                    : crlzw_pkg::ST_SEED)
                               : crlzw_pkg::ST_OUT;
        end else begin
          tbl_addr = probe + 12'd1;
        end
      end
      crlzw_pkg::ST_LINK: begin
        tbl_we          = 1'b1;
        tbl_addr        = slot;
        tbl_wdata       = tail_q;
        tbl_wdata.chain = wr_slot;
        state_next      = crlzw_pkg::ST_WRITE;
      end
      crlzw_pkg::ST_WRITE: begin
        tbl_we             = 1'b1;
        tbl_addr           = wr_slot;
        tbl_wdata.used     = 1'b1;
        tbl_wdata.prefix   = stored_q;
        tbl_wdata.follower = foll_q;
        state_next = seeding ? ((seed_i == 8'hFF) ? (from_reset ? crlzw_pkg::ST_IDLE
                                                                : crlzw_pkg::ST_OUT)
                                                  : crlzw_pkg::ST_SEED)
                             : crlzw_pkg::ST_OUT;
      end
      crlzw_pkg::ST_DWALK: begin
        if (first && !first_seen) begin
          stk_we     = 1'b1;
          stk_addr   = 12'd0;
          state_next = crlzw_pkg::ST_OUT;
        end else if (first && !rd.used) begin
          stk_we    = 1'b1;
          stk_addr  = sp[11:0];
          stk_wdata = final_char;
          tbl_addr  = prev;
        end else begin
          stk_we   = 1'b1;
          stk_addr = sp[11:0];
          if (sp == 13'd4095) begin
            state_next = crlzw_pkg::ST_OUT;
          end else if (!rd.prefix[12]) begin
            tbl_addr = rd.prefix[11:0];
          end else if (entries_left != 12'd0) begin
            state_next = crlzw_pkg::ST_HASH;
          end else begin
            state_next = crlzw_pkg::ST_OUT;
          end
        end
      end
      crlzw_pkg::ST_PULL: state_next = crlzw_pkg::ST_OUT;
      crlzw_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = crlzw_pkg::ST_IDLE;
        end
      end
      default: state_next = crlzw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crlzw_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_mode    <= 1'b0;
      seed_mode    <= 1'b0;
      from_reset   <= 1'b1;
      seeding      <= 1'b1;
      seed_i       <= 8'd0;
      clr_cnt      <= 13'd0;
      sp           <= 13'd0;
      prev         <= 12'd0;
      final_char   <= 8'd0;
      entries_left <= crlzw_pkg::ENTRIES_INIT;
      phase        <= 2'd0;
      partial      <= 12'd0;
      first_seen   <= 1'b0;
      first        <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_wr) begin
        hash_mode <= pwdata[0];
      end
      if (m_tready && state != crlzw_pkg::ST_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        crlzw_pkg::ST_IDLE: begin
          if (acc) begin
            res_byte <= 8'd0;
            priority case (s_tuser)
              crlzw_pkg::OP_START: begin
                res_status   <= crlzw_pkg::STS_NONE;
                res_len      <= 13'd0;
                res_last     <= 1'b0;
                from_reset   <= 1'b0;
                seed_mode    <= hash_mode;
                seeding      <= 1'b1;
                seed_i       <= 8'd0;
                clr_cnt      <= 13'd0;
                sp           <= 13'd0;
                prev         <= 12'd0;
                final_char   <= 8'd0;
                entries_left <= crlzw_pkg::ENTRIES_INIT;
                phase        <= 2'd0;
                partial      <= 12'd0;
                first_seen   <= 1'b0;
              end
              crlzw_pkg::OP_BYTE: begin
                res_status <= crlzw_pkg::STS_NONE;
                res_len    <= 13'd0;
                res_last   <= 1'b0;
                if (phase == 2'd0) begin
                  partial <= {s_tdata, 4'd0};
                  phase   <= 2'd1;
                end else begin
                  code_q <= code_in;
                  first  <= 1'b1;
                  sp     <= 13'd0;
                  if (phase == 2'd1) begin
                    partial <= {s_tdata[3:0], 8'd0};
                    phase   <= 2'd2;
                  end else begin
                    partial <= 12'd0;
                    phase   <= 2'd0;
                  end
                end
              end
              crlzw_pkg::OP_PULL: begin
                if (sp == 13'd0) begin
                  res_status <= crlzw_pkg::STS_EMPTY;
                  res_len    <= 13'd0;
                  res_last   <= 1'b0;
                end else begin
                  sp         <= sp_dec;
                  res_status <= crlzw_pkg::STS_BYTE;
                  res_len    <= sp_dec;
                  res_last   <= (sp_dec == 13'd0);
                end
              end
              default: begin
                res_status <= crlzw_pkg::STS_NONE;
                res_len    <= 13'd0;
                res_last   <= 1'b0;
              end
            endcase
          end
        end
        crlzw_pkg::ST_CLEAR: clr_cnt <= clr_cnt + 13'd1;
        crlzw_pkg::ST_SEED: begin
          pred_q   <= crlzw_pkg::ROOT_HASH_PRED;
          foll_q   <= seed_i;
          stored_q <= crlzw_pkg::NO_PREFIX;
        end
        crlzw_pkg::ST_HASH: prod_q <= prod;
        crlzw_pkg::ST_HRD: slot <= hash_val;
        crlzw_pkg::ST_LOOK0, crlzw_pkg::ST_CHAIN: begin
          if (state == crlzw_pkg::ST_LOOK0 && !rd.used) begin
            wr_slot <= slot;
          end else if (rd.chain != 12'd0) begin
            slot <= rd.chain;
          end else begin
            tail_q <= rd;
            probe  <= slot + crlzw_pkg::PROBE_STEP;
            pcnt   <= 12'd0;
          end
        end
        crlzw_pkg::ST_PROBE: begin
          if (!rd.used) begin
            wr_slot <= probe;
          end else begin
            probe <= probe + 12'd1;
            pcnt  <= pcnt + 12'd1;
            if (add_fail) begin
              if (seeding) begin
                if (seed_i == 8'hFF) seeding <= 1'b0;
                seed_i <= seed_i + 8'd1;
              end else begin
                prev       <= code_q;
                res_status <= crlzw_pkg::STS_DECODED;
                res_len    <= sp;
              end
            end
          end
        end
        crlzw_pkg::ST_LINK: ;
        crlzw_pkg::ST_WRITE: begin
          if (seeding) begin
            if (seed_i == 8'hFF) seeding <= 1'b0;
            seed_i <= seed_i + 8'd1;
          end else begin
            prev       <= code_q;
            res_status <= crlzw_pkg::STS_DECODED;
            res_len    <= sp;
          end
        end
        crlzw_pkg::ST_DWALK: begin
          first <= 1'b0;
          if (first && !first_seen) begin
            first_seen <= 1'b1;
            final_char <= rd.follower;
            prev       <= code_q;
            sp         <= 13'd1;
            res_status <= crlzw_pkg::STS_DECODED;
            res_len    <= 13'd1;
          end else if (first && !rd.used) begin
            sp <= sp_inc;
          end else if (sp == 13'd4095) begin
            sp         <= 13'd0;
            res_status <= crlzw_pkg::STS_OVERFLOW;
            res_len    <= 13'd0;
          end else if (!rd.prefix[12]) begin
            sp <= sp_inc;
          end else begin
            sp         <= sp_inc;
            final_char <= rd.follower;
            if (entries_left != 12'd0) begin
              entries_left <= entries_left - 12'd1;
              pred_q       <= {4'd0, prev};
              foll_q       <= rd.follower;
              stored_q     <= {1'b0, prev};
            end else begin
              prev       <= code_q;
              res_status <= crlzw_pkg::STS_DECODED;
              res_len    <= sp_inc;
            end
          end
        end
        crlzw_pkg::ST_PULL: res_byte <= stk_rdata;
        crlzw_pkg::ST_OUT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= {3'd0, res_len, res_byte};
            m_tlast  <= res_last;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    (state == crlzw_pkg::ST_CLEAR) |-> !s_tready)
    else $error("item accepted during table clear");

  a_entries_bound: assert property (@(posedge clk) disable iff (rst)
    entries_left <= crlzw_pkg::ENTRIES_INIT)
    else $error("entry budget above its start value");

  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    !sp[12])
    else $error("stack pointer past table size");

  a_write_used: assert property (@(posedge clk) disable iff (rst)
    (state == crlzw_pkg::ST_WRITE) |=> (state != crlzw_pkg::ST_WRITE))
    else $error("entry write repeated");
`endif

endmodule
